/* hw/rtl/wsdt_pkg.sv */
// ----------------------------------------------------------------------------
// wsdt_pkg
// Shared types and constants of the station discovery table.
// ----------------------------------------------------------------------------
package wsdt_pkg;

  localparam int ApSlotsDefault      = 64;
  localparam int StationSlotsDefault = 64;
  localparam int MacW   = 48;
  localparam int RssiW  = 8;
  localparam int TimeW  = 32;
  localparam int SlotW  = 6;
  localparam int McastBit = 40;

  localparam logic [1:0] CmdApClear = 2'd0;
  localparam logic [1:0] CmdApAdd   = 2'd1;
  localparam logic [1:0] CmdFrame   = 2'd2;

  localparam logic [1:0] FtypeMgmt  = 2'd0;
  localparam logic [1:0] FtypeData  = 2'd2;
  localparam logic [3:0] FsubProbeReq = 4'd4;

  typedef enum logic [2:0] {
    ACT_IGNORED     = 3'd0,
    ACT_STA_UPDATED = 3'd1,
    ACT_STA_INSERT  = 3'd2,
    ACT_STA_FULL    = 3'd3,
    ACT_AP_ADDED    = 3'd4,
    ACT_AP_FULL     = 3'd5,
    ACT_AP_CLEARED  = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    OP_AP_CLEAR = 2'd0,
    OP_AP_ADD   = 2'd1,
    OP_FRAME    = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              probe;
    logic [MacW-1:0]   addr_one;
    logic [MacW-1:0]   addr_two;
    logic [RssiW-1:0]  rssi;
    logic [TimeW-1:0]  time_ms;
  } job_t;

  typedef struct packed {
    action_t           action;
    logic [SlotW-1:0]  slot;
    logic [MacW-1:0]   station_mac;
    logic [MacW-1:0]   assoc_bssid;
    logic              bssid_known;
  } result_t;

endpackage

/* hw/rtl/wsdt_front.sv */
// ----------------------------------------------------------------------------
// wsdt_front
// Accept input words, classify them and push jobs into a two-entry queue.
// ----------------------------------------------------------------------------
module wsdt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              sniff_enable,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [1:0]        cmd,
  input  logic [1:0]        frame_type,
  input  logic [3:0]        frame_subtype,
  input  logic [47:0]       addr_one,
  input  logic [47:0]       addr_two,
  input  logic [7:0]        rssi,
  input  logic [31:0]       time_ms,
  output logic              job_valid,
  input  logic              job_ready,
  output wsdt_pkg::job_t    job
);

  wsdt_pkg::job_t q [2];
  logic           rd_ptr;
  logic           wr_ptr;
  logic [1:0]     fill;
  wsdt_pkg::job_t in_job;
  logic           push;
  logic           pop;

  always_comb begin
    in_job.addr_one = addr_one;
    in_job.addr_two = addr_two;
    in_job.rssi     = rssi;
    in_job.time_ms  = time_ms;
    in_job.probe    = (frame_type == wsdt_pkg::FtypeMgmt) &&
                      (frame_subtype == wsdt_pkg::FsubProbeReq);
    in_job.op       = wsdt_pkg::OP_NOP;
    if (cmd == wsdt_pkg::CmdApClear) begin
      in_job.op = wsdt_pkg::OP_AP_CLEAR;
    end else if (cmd == wsdt_pkg::CmdApAdd) begin
      in_job.op = wsdt_pkg::OP_AP_ADD;
    end else if (cmd == wsdt_pkg::CmdFrame && sniff_enable &&
                 (in_job.probe || frame_type == wsdt_pkg::FtypeData)) begin
      in_job.op = wsdt_pkg::OP_FRAME;
    end
  end

  assign s_tready  = (fill != 2'd2);
  assign push      = s_tvalid && s_tready;
  assign job_valid = (fill != 2'd0);
  assign pop       = job_valid && job_ready;
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_job;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue overfilled");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0) |-> !pop) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2) |-> !push) else $error("push into full queue");

endmodule

/* hw/rtl/wsdt_back.sv */
// ----------------------------------------------------------------------------
// wsdt_back
// Run jobs against the access-point and station tables; frames by sequential scans.
// ----------------------------------------------------------------------------
module wsdt_back #(
  parameter int ApSlots      = wsdt_pkg::ApSlotsDefault,
  parameter int StationSlots = wsdt_pkg::StationSlotsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  wsdt_pkg::job_t     job,
  output logic               m_tvalid,
  input  logic               m_tready,
  output wsdt_pkg::result_t  res
);

  localparam int ApIdxW = (ApSlots > 1) ? $clog2(ApSlots) : 1;
  localparam int StIdxW = (StationSlots > 1) ? $clog2(StationSlots) : 1;
  localparam int ApCntW = $clog2(ApSlots + 1);
  localparam int StCntW = $clog2(StationSlots + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_APSCAN = 6'b000010,
    S_APWAIT = 6'b000100,
    S_STSCAN = 6'b001000,
    S_STWAIT = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;

  logic [47:0] ap_mem [ApSlots];
  logic [47:0] st_addr [StationSlots];
  logic [47:0] st_bssid [StationSlots];
  logic        st_has [StationSlots];
  logic [7:0]  st_sig [StationSlots];
  logic [31:0] st_seen [StationSlots];

  logic [ApCntW-1:0] ap_count;
  logic [StCntW-1:0] st_count;
  wsdt_pkg::job_t    cur;
  logic [ApCntW-1:0] ap_idx;
  logic [StCntW-1:0] st_idx;
  logic [47:0]       ap_rd;
  logic [47:0]       st_rd;
  logic              st_rd_has;
  logic [47:0]       st_rd_bssid;
  logic              k1;
  logic              k2;
  logic [47:0]       sta;
  logic [47:0]       bss;
  logic              with_bss;
  logic              found;
  logic [StCntW-1:0] hit_idx;
  logic              out_full;

  assign job_ready = (state == S_IDLE) && !out_full;
  assign m_tvalid  = out_full;

  always_comb begin
    with_bss = 1'b0;
    sta = cur.addr_two;
    bss = 48'd0;
    if (!cur.probe) begin
      with_bss = 1'b1;
      if (k1) begin
        sta = cur.addr_two;
        bss = cur.addr_one;
      end else begin
        sta = cur.addr_one;
        bss = cur.addr_two;
      end
    end
  end

  always_ff @(posedge clk) begin
    ap_rd       <= ap_mem[ap_idx[ApIdxW-1:0]];
    st_rd       <= st_addr[st_idx[StIdxW-1:0]];
    st_rd_has   <= st_has[st_idx[StIdxW-1:0]];
    st_rd_bssid <= st_bssid[st_idx[StIdxW-1:0]];
    if (rst) begin
      state    <= S_IDLE;
      ap_count <= '0;
      st_count <= '0;
      out_full <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) out_full <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            cur    <= job;
            ap_idx <= '0;
            st_idx <= '0;
            k1     <= 1'b0;
            k2     <= 1'b0;
            found  <= 1'b0;
            unique case (job.op)
              wsdt_pkg::OP_AP_CLEAR: begin
                ap_count <= '0;
                res      <= '{action: wsdt_pkg::ACT_AP_CLEARED, default: '0};
                out_full <= 1'b1;
              end
              wsdt_pkg::OP_AP_ADD: begin
                if (ap_count < ApCntW'(ApSlots)) begin
                  ap_mem[ap_count[ApIdxW-1:0]] <= job.addr_one;
                  ap_count <= ap_count + 1'b1;
                  res      <= '{action: wsdt_pkg::ACT_AP_ADDED, default: '0};
                end else begin
                  res <= '{action: wsdt_pkg::ACT_AP_FULL, default: '0};
                end
                out_full <= 1'b1;
              end
              wsdt_pkg::OP_FRAME: begin
                res   <= '{action: wsdt_pkg::ACT_IGNORED, default: '0};
                state <= job.probe ? S_STSCAN : S_APSCAN;
              end
              default: begin
                res      <= '{action: wsdt_pkg::ACT_IGNORED, default: '0};
                out_full <= 1'b1;
              end
            endcase
          end
        end
        S_APSCAN: begin
          if (ap_idx >= ap_count) begin
            if (k1 == k2) begin
              state    <= S_IDLE;
              out_full <= 1'b1;
            end else begin
              state <= S_STSCAN;
            end
          end else begin
            state <= S_APWAIT;
          end
        end
        S_APWAIT: begin
          if (ap_rd == cur.addr_one) k1 <= 1'b1;
          if (ap_rd == cur.addr_two) k2 <= 1'b1;
          ap_idx <= ap_idx + 1'b1;
          state  <= S_APSCAN;
        end
        S_STSCAN: begin
          if (sta[wsdt_pkg::McastBit]) begin
            state    <= S_IDLE;
            out_full <= 1'b1;
          end else if (st_idx >= st_count) begin
            state <= S_FINISH;
          end else begin
            state <= S_STWAIT;
          end
        end
        S_STWAIT: begin
          if (st_rd == sta) begin
            found   <= 1'b1;
            hit_idx <= st_idx;
            state   <= S_FINISH;
          end else begin
            st_idx <= st_idx + 1'b1;
            state  <= S_STSCAN;
          end
        end
        S_FINISH: begin
          res.station_mac <= sta;
          state    <= S_IDLE;
          out_full <= 1'b1;
          if (found) begin
            st_sig[hit_idx[StIdxW-1:0]]  <= cur.rssi;
            st_seen[hit_idx[StIdxW-1:0]] <= cur.time_ms;
            res.action <= wsdt_pkg::ACT_STA_UPDATED;
            res.slot   <= wsdt_pkg::SlotW'(hit_idx);
            if (with_bss) begin
              st_bssid[hit_idx[StIdxW-1:0]] <= bss;
              st_has[hit_idx[StIdxW-1:0]]   <= 1'b1;
              res.assoc_bssid <= bss;
              res.bssid_known <= 1'b1;
            end else begin
              res.assoc_bssid <= st_rd_has ? st_rd_bssid : 48'd0;
              res.bssid_known <= st_rd_has;
            end
          end else if (st_count >= StCntW'(StationSlots)) begin
            res.action <= wsdt_pkg::ACT_STA_FULL;
          end else begin
            st_addr[st_count[StIdxW-1:0]]  <= sta;
            st_bssid[st_count[StIdxW-1:0]] <= bss;
            st_has[st_count[StIdxW-1:0]]   <= with_bss;
            st_sig[st_count[StIdxW-1:0]]   <= cur.rssi;
            st_seen[st_count[StIdxW-1:0]]  <= cur.time_ms;
            st_count        <= st_count + 1'b1;
            res.action      <= wsdt_pkg::ACT_STA_INSERT;
            res.slot        <= wsdt_pkg::SlotW'(st_count);
            res.assoc_bssid <= bss;
            res.bssid_known <= with_bss;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ap_bound: assert property (@(posedge clk) disable iff (rst)
    ap_count <= ApCntW'(ApSlots)) else $error("ap count overflow");
  a_st_bound: assert property (@(posedge clk) disable iff (rst)
    st_count <= StCntW'(StationSlots)) else $error("station count overflow");
  a_st_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> st_count >= $past(st_count)) else $error("station count fell");

endmodule

/* hw/rtl/wlan_station_discovery_table_core.sv */
// ----------------------------------------------------------------------------
// wlan_station_discovery_table_core
// Access-point list and station table fed by observed frame headers.
// ----------------------------------------------------------------------------
// Each word gives one result word. AP commands, unused commands and frames
// seen with sniffing off are answered without a scan; a frame is matched by
// linear scans of the AP table (data frames only) and the station table over
// the entries in use. The back is ready for its next job in the cycle after
// its result word is accepted. A two-word queue lets the front accept while
// the back scans.
module wlan_station_discovery_table_core #(
  parameter int ApSlots      = wsdt_pkg::ApSlotsDefault,
  parameter int StationSlots = wsdt_pkg::StationSlotsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [0:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // cmd[1:0], frame_type[3:2], frame_subtype[7:4], addr_one[55:8],
  // addr_two[103:56], rssi[111:104], time_ms[143:112]
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // action[2:0], slot[8:3], station_mac[56:9], assoc_bssid[104:57],
  // bssid_known[105], zero[111:106]
  output logic [111:0] m_tdata
);

  logic                sniff_enable;
  logic                job_valid;
  logic                job_ready;
  wsdt_pkg::job_t      job;
  wsdt_pkg::result_t   res;

  assign pready = 1'b1;
  assign prdata = {31'd0, sniff_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      sniff_enable <= 1'b0;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      sniff_enable <= pwdata[0];
    end
  end

  wsdt_front u_front (
    .clk, .rst, .sniff_enable, .s_tvalid, .s_tready,
    .cmd(s_tdata[1:0]), .frame_type(s_tdata[3:2]), .frame_subtype(s_tdata[7:4]),
    .addr_one(s_tdata[55:8]), .addr_two(s_tdata[103:56]),
    .rssi(s_tdata[111:104]), .time_ms(s_tdata[143:112]),
    .job_valid, .job_ready, .job
  );

  wsdt_back #(.ApSlots(ApSlots), .StationSlots(StationSlots)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job, .m_tvalid, .m_tready, .res
  );

  assign m_tdata = {6'd0, res.bssid_known, res.assoc_bssid, res.station_mac,
                    res.slot, res.action};

endmodule

/* test/tb_wlan_station_discovery_table_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wlan_station_discovery_table_core
// Drives AP list commands and observed frame headers into the discovery
// table, predicts each result word from a local copy of both tables and
// compares it field by field, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_wlan_station_discovery_table_core;
  import wsdt_pkg::*;

  localparam int ApN  = 64;
  localparam int StaN = 64;
  localparam int CycleLimit = 2000000;

  typedef struct {
    logic [1:0]  cmd;
    logic [1:0]  ftype;
    logic [3:0]  fsub;
    logic [47:0] a1;
    logic [47:0] a2;
    logic [7:0]  rssi;
    logic [31:0] tms;
  } frame_word_t;

  typedef struct packed {
    action_t     action;
    logic [5:0]  slot;
    logic [47:0] mac;
    logic [47:0] bssid;
    logic        known;
  } table_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [0:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [143:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [111:0] m_tdata;

  wlan_station_discovery_table_core dut (.*);

  always #6 clk = ~clk;

  logic        sniff_on;
  logic [47:0] ap_list [ApN];
  int          ap_used;
  logic [47:0] sta_mac [StaN];
  logic [47:0] sta_bss [StaN];
  logic        sta_has [StaN];
  int          sta_used;

  table_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0, recv_stall = 0;

  task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit ap_hit(input logic [47:0] a);
    for (int i = 0; i < ap_used; i++) if (ap_list[i] == a) return 1'b1;
    return 1'b0;
  endfunction

  function automatic table_result_t station_upsert(input logic [47:0] mac, input bit wb,
                                                   input logic [47:0] bss);
    table_result_t r;
    r = '{ACT_IGNORED, 6'd0, 48'd0, 48'd0, 1'b0};
    if (mac[McastBit]) return r;
    for (int i = 0; i < sta_used; i++) begin
      if (sta_mac[i] == mac) begin
        if (wb) begin
          sta_bss[i] = bss;
          sta_has[i] = 1'b1;
        end
        r = '{ACT_STA_UPDATED, 6'(i), mac, sta_has[i] ? sta_bss[i] : 48'd0, sta_has[i]};
        return r;
      end
    end
    if (sta_used >= StaN) begin
      r = '{ACT_STA_FULL, 6'd0, mac, 48'd0, 1'b0};
      return r;
    end
    sta_mac[sta_used] = mac;
    sta_bss[sta_used] = wb ? bss : 48'd0;
    sta_has[sta_used] = wb;
    r = '{ACT_STA_INSERT, 6'(sta_used), mac, wb ? bss : 48'd0, wb};
    sta_used++;
    return r;
  endfunction

  function automatic table_result_t predict_table(input frame_word_t w);
    table_result_t r;
    bit k1, k2;
    r = '{ACT_IGNORED, 6'd0, 48'd0, 48'd0, 1'b0};
    case (w.cmd)
      CmdApClear: begin
        ap_used = 0;
        r.action = ACT_AP_CLEARED;
      end
      CmdApAdd: begin
        if (ap_used < ApN) begin
          ap_list[ap_used] = w.a1;
          ap_used++;
          r.action = ACT_AP_ADDED;
        end else r.action = ACT_AP_FULL;
      end
      CmdFrame: begin
        if (sniff_on) begin
          if (w.ftype == FtypeMgmt && w.fsub == FsubProbeReq) begin
            r = station_upsert(w.a2, 1'b0, 48'd0);
          end else if (w.ftype == FtypeData) begin
            k1 = ap_hit(w.a1);
            k2 = ap_hit(w.a2);
            if (k1 && !k2) r = station_upsert(w.a2, 1'b1, w.a1);
            else if (k2 && !k1) r = station_upsert(w.a1, 1'b1, w.a2);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: check and randomly stall
  always @(posedge clk) begin
    table_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report("unexpected word", m_tdata[56:9], 48'd0);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[2:0] != want.action)
            report("action", 48'(m_tdata[2:0]), 48'(want.action));
          if (m_tdata[8:3] != want.slot)
            report("slot", 48'(m_tdata[8:3]), 48'(want.slot));
          if (m_tdata[56:9] != want.mac) report("station_mac", m_tdata[56:9], want.mac);
          if (m_tdata[104:57] != want.bssid)
            report("assoc_bssid", m_tdata[104:57], want.bssid);
          if (m_tdata[105] != want.known)
            report("bssid_known", 48'(m_tdata[105]), 48'(want.known));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_sniff(input logic v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sniff_on = v;
  endtask

  task automatic send_word(input frame_word_t w);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {w.tms, w.rssi, w.a2, w.a1, w.fsub, w.ftype, w.cmd};
    do @(posedge clk); while (!s_tready);
    pending_results = {pending_results, predict_table(w)};
  endtask

  task automatic settle;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic drain;
    settle();
    repeat (300) @(posedge clk);
  endtask

  logic [47:0] ap_pool [8];
  logic [47:0] sta_pool [24];

  function automatic frame_word_t random_word();
    frame_word_t w;
    int k;
    w.cmd = 2'(CmdFrame);
    w.ftype = 2'($urandom_range(3));
    w.fsub = 4'($urandom_range(15));
    w.a1 = 48'({$urandom, $urandom});
    w.a2 = 48'({$urandom, $urandom});
    w.rssi = 8'($urandom);
    w.tms = $urandom;
    k = $urandom_range(99);
    if (k < 3) w.cmd = 2'(CmdApClear);
    else if (k < 10) begin
      w.cmd = 2'(CmdApAdd);
      w.a1 = ap_pool[$urandom_range(7)];
    end else if (k < 12) w.cmd = 2'(OP_NOP);
    else if (k < 40) begin
      w.ftype = FtypeMgmt; w.fsub = FsubProbeReq;
      w.a2 = sta_pool[$urandom_range(23)];
    end else if (k < 88) begin
      w.ftype = FtypeData;
      if ($urandom_range(1)) begin
        w.a1 = ap_pool[$urandom_range(7)]; w.a2 = sta_pool[$urandom_range(23)];
      end else begin
        w.a2 = ap_pool[$urandom_range(7)]; w.a1 = sta_pool[$urandom_range(23)];
      end
      if ($urandom_range(9) == 0) w.a1 = ap_pool[$urandom_range(7)];
    end
    return w;
  endfunction

  frame_word_t directed [$];
  table_result_t dir_want [$];
  bit dir_has [$];

  task automatic add_row(input frame_word_t w, input bit h, input table_result_t r);
    directed = {directed, w}; dir_has = {dir_has, h}; dir_want = {dir_want, r};
  endtask

  task automatic add_frame(input frame_word_t w);
    directed = {directed, w};
  endtask

  initial begin
    frame_word_t w;
    table_result_t r, z;
    sniff_on = 1'b0; ap_used = 0; sta_used = 0;
    z = '{ACT_IGNORED, 6'd0, 48'd0, 48'd0, 1'b0};
    foreach (ap_pool[i]) ap_pool[i] = 48'({$urandom, $urandom}) & ~(48'd1 << McastBit);
    foreach (sta_pool[i]) begin
      sta_pool[i] = 48'({$urandom, $urandom});
      if (i < 18) sta_pool[i][McastBit] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    w = '{CmdFrame, FtypeMgmt, FsubProbeReq, 48'h0, 48'h02_0000_0000_01, 8'h80, 32'd0};
    add_row(w, 1, z);
    w.cmd = 2'(OP_NOP); add_row(w, 1, z);
    w.cmd = CmdApClear; r = z; r.action = ACT_AP_CLEARED; add_row(w, 1, r);
    w = '{CmdApAdd, 2'd3, 4'hf, 48'hffff_ffff_fffe, 48'hffff_ffff_ffff, 8'h7f, 32'hffffffff};
    r.action = ACT_AP_ADDED; add_row(w, 1, r);
    w.a1 = 48'h0; add_row(w, 1, r);
    foreach (directed[i]) begin
      w = directed[i];
      send_word(w);
      if (dir_has[i] && pending_results[$] != dir_want[i])
        report("directed row", 48'(i), 48'd0);
    end
    drain();
    write_sniff(1'b1);
    directed.delete();
    // probe, multicast probe, data both ways, both known, neither known, other frame
    add_frame('{CmdFrame, FtypeMgmt, FsubProbeReq, 48'h0, 48'h0, 8'h80, 32'd0});
    add_frame('{CmdFrame, FtypeMgmt, FsubProbeReq, 48'h0, 48'h01_0000_0000_00,
                8'h7f, 32'hffffffff});
    add_frame('{CmdFrame, FtypeData, 4'hf, 48'hffff_ffff_fffe, 48'h0, 8'h01, 32'd5});
    add_frame('{CmdFrame, FtypeData, 4'h0, 48'h12_3456_789a, 48'hffff_ffff_fffe,
                8'hff, 32'd6});
    add_frame('{CmdFrame, FtypeData, 4'h0, 48'hffff_ffff_fffe, 48'h0, 8'h01, 32'd7});
    add_frame('{CmdFrame, FtypeData, 4'h0, 48'h0, 48'hfffe_ffff_ffff, 8'h01, 32'd8});
    add_frame('{CmdFrame, FtypeData, 4'h0, 48'h5, 48'h6, 8'h01, 32'd9});
    add_frame('{CmdFrame, 2'd1, FsubProbeReq, 48'h0, 48'h7, 8'h01, 32'd9});
    add_frame('{CmdFrame, 2'd3, FsubProbeReq, 48'h0, 48'h7, 8'h01, 32'd9});
    add_frame('{CmdFrame, FtypeMgmt, FsubProbeReq, 48'h0, 48'hfeff_ffff_ffff,
                8'h00, 32'd1});
    foreach (directed[i]) send_word(directed[i]);
    // fill AP table past full
    for (int i = 0; i < ApN; i++) begin
      w = '{CmdApAdd, 2'd0, 4'd0, 48'({$urandom, $urandom}), 48'd0, 8'd0, 32'd0};
      send_word(w);
    end
    // fill station table past full
    for (int i = 0; i < StaN + 3; i++) begin
      w = '{CmdFrame, FtypeMgmt, FsubProbeReq, 48'd0,
            48'({$urandom, $urandom}) & ~(48'd1 << McastBit), 8'($urandom), $urandom};
      send_word(w);
    end
    drain();

    // random phases with varied idle and stall settings; sniffing is off in phase 3
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 48; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 48; end
        default: begin send_idle = 9; recv_stall = 9; end
      endcase
      if (ph == 3) write_sniff(1'b0);
      if (ph == 4) write_sniff(1'b1);
      for (int i = 0; i < 100; i++) begin
        send_word(random_word());
        if (i == 50) settle();
      end
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
